// File: rtl/core/hcsg_pkg.sv
// Shared types, constants and tables of the Hilbert curve segment generator.
// Holds the microcode store, the phase dispatch and the nine-entry color table.
// No dependencies.
package hcsg_pkg;

	localparam int MAX_DEPTH  = 12;
	localparam int COORD_BITS = 12;
	localparam int LVL_BITS   = $clog2(MAX_DEPTH + 1);
	localparam int IDX_BITS   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int HEAD_BITS  = 6;
	localparam int PH_BITS    = 3;
	localparam int UPC_BITS   = 3;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_BITS   = 12;

	localparam logic [HEAD_BITS-1:0] HEAD_MOD   = HEAD_BITS'(36);
	localparam logic [HEAD_BITS-1:0] HEAD_START = HEAD_BITS'(28);

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_DEPTH   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STEP    = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_START_X = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_START_Y = 2'd3;

	// Frame phases.
	localparam logic [PH_BITS-1:0] PH_ENTER  = 3'd0;
	localparam logic [PH_BITS-1:0] PH_FIRST  = 3'd1;
	localparam logic [PH_BITS-1:0] PH_SECOND = 3'd2;
	localparam logic [PH_BITS-1:0] PH_THIRD  = 3'd3;
	localparam logic [PH_BITS-1:0] PH_EXIT   = 3'd4;

	// Microcode addresses.
	localparam logic [UPC_BITS-1:0] UA_FETCH   = 3'd0;
	localparam logic [UPC_BITS-1:0] UA_P0      = 3'd1;
	localparam logic [UPC_BITS-1:0] UA_P1      = 3'd2;
	localparam logic [UPC_BITS-1:0] UA_P2      = 3'd3;
	localparam logic [UPC_BITS-1:0] UA_P3_TURN = 3'd4;
	localparam logic [UPC_BITS-1:0] UA_P3_DRAW = 3'd5;
	localparam logic [UPC_BITS-1:0] UA_P4      = 3'd6;

	// Sequencing codes of a control word.
	localparam logic [1:0] J_END      = 2'd0;
	localparam logic [1:0] J_NEXT     = 2'd1;
	localparam logic [1:0] J_DISPATCH = 2'd2;

	typedef struct packed {
		logic                turn_en;
		logic                turn_inv;
		logic                draw_en;
		logic                phase_wr;
		logic [PH_BITS-1:0]  phase_val;
		logic                push_en;
		logic                push_inv;
		logic                pop_en;
		logic [1:0]          jump;
		logic [UPC_BITS-1:0] nxt_addr;
	} uword_t;

	typedef struct packed {
		logic   go;
		logic   set_done;
		uword_t uw;
	} ctrl_t;

	typedef struct packed {
		logic               start;
		logic               level_zero;
		logic [PH_BITS-1:0] phase;
		logic               out_free;
	} stat_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// The microprogram. Drawing steps read the heading before any turn in the same step.
	function automatic uword_t ucode(input logic [UPC_BITS-1:0] addr);
		uword_t w;
		w = '0;
		unique case (addr)
			UA_FETCH: begin
				w.jump = J_DISPATCH;
			end
			UA_P0: begin
				w.turn_en = 1'b1;
				w.phase_wr = 1'b1; w.phase_val = PH_FIRST;
				w.push_en = 1'b1; w.push_inv = 1'b1;
				w.jump = J_NEXT; w.nxt_addr = UA_FETCH;
			end
			UA_P1: begin
				w.draw_en = 1'b1;
				w.turn_en = 1'b1; w.turn_inv = 1'b1;
				w.phase_wr = 1'b1; w.phase_val = PH_SECOND;
				w.push_en = 1'b1;
				w.jump = J_END;
			end
			UA_P2: begin
				w.draw_en = 1'b1;
				w.phase_wr = 1'b1; w.phase_val = PH_THIRD;
				w.push_en = 1'b1;
				w.jump = J_END;
			end
			UA_P3_TURN: begin
				w.turn_en = 1'b1; w.turn_inv = 1'b1;
				w.jump = J_NEXT; w.nxt_addr = UA_P3_DRAW;
			end
			UA_P3_DRAW: begin
				w.draw_en = 1'b1;
				w.phase_wr = 1'b1; w.phase_val = PH_EXIT;
				w.push_en = 1'b1; w.push_inv = 1'b1;
				w.jump = J_END;
			end
			UA_P4: begin
				w.turn_en = 1'b1;
				w.pop_en = 1'b1;
				w.jump = J_NEXT; w.nxt_addr = UA_FETCH;
			end
			default: begin
				w.jump = J_END;
			end
		endcase
		return w;
	endfunction

	function automatic logic [UPC_BITS-1:0] dispatch(input logic [PH_BITS-1:0] ph);
		logic [UPC_BITS-1:0] a;
		unique case (ph)
			PH_ENTER:  a = UA_P0;
			PH_FIRST:  a = UA_P1;
			PH_SECOND: a = UA_P2;
			PH_THIRD:  a = UA_P3_TURN;
			default:   a = UA_P4;
		endcase
		return a;
	endfunction

	// Color at heading mod 9, reduced by two compare-and-subtract steps.
	function automatic rgb_t head_color(input logic [HEAD_BITS-1:0] h);
		logic [HEAD_BITS-1:0] c;
		rgb_t o;
		c = h;
		if (c >= HEAD_BITS'(18)) c = c - HEAD_BITS'(18);
		if (c >= HEAD_BITS'(9))  c = c - HEAD_BITS'(9);
		case (c[3:0])
			4'd0:    o = '{r: 8'd0,   g: 8'd255, b: 8'd0};
			4'd1:    o = '{r: 8'd85,  g: 8'd170, b: 8'd0};
			4'd2:    o = '{r: 8'd170, g: 8'd85,  b: 8'd0};
			4'd3:    o = '{r: 8'd255, g: 8'd0,   b: 8'd0};
			4'd4:    o = '{r: 8'd170, g: 8'd0,   b: 8'd85};
			4'd5:    o = '{r: 8'd85,  g: 8'd0,   b: 8'd170};
			4'd6:    o = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
			4'd7:    o = '{r: 8'd0,   g: 8'd85,  b: 8'd170};
			default: o = '{r: 8'd0,   g: 8'd170, b: 8'd85};
		endcase
		return o;
	endfunction

endpackage

// File: rtl/core/hilbert_curve_segment_generator_core.sv
// Top level of the Hilbert curve segment generator: configuration registers,
// pen and frame-stack datapath, output register. Depends on hcsg_pkg and hcsg_sequencer.
//
// Usage. Configuration is written through cfg_we/cfg_index/cfg_data while the block
// is idle: index 0 curve depth, 1 step length, 2 start x, 3 start y. Requests arrive
// on in_valid/in_ready with one field, restart. A request with restart high loads the
// pen from start x/y, sets the heading count to 28 and latches the depth (saturated to
// the stack depth); it produces no segment and completes in the cycle it is accepted.
// A request with restart low walks the frame stack to the next segment and presents it
// on out_valid/out_ready together with its color and a final_segment mark.
// Once the curve is finished, requests produce nothing.
// Timing: the sequencer executes one microcode step per cycle unless a drawing step
// stalls on the output register. A request begins by fetching the top frame; a descent
// runs the enter step and fetches again, an unwind the exit step and a fetch, a first
// or second segment a single drawing step and a third a turn step then a drawing step.
// How long a segment request keeps the sequencer busy is set by the number of levels
// the frame stack moves; the first request after a restart descends the whole depth
// and is the longest. The next request is accepted once the sequencer is idle again.
// Segments are held in an output register, so the next request is accepted while a
// result waits; if the receiver stalls, the sequencer holds in its drawing step until
// the output register frees up. Reset leaves the curve finished, the depth and step
// at one and the start at the origin; a restart is required before drawing.
module hilbert_curve_segment_generator_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [hcsg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [hcsg_pkg::CFG_BITS-1:0]       cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [hcsg_pkg::COORD_BITS-1:0]     from_x,
	output logic [hcsg_pkg::COORD_BITS-1:0]     from_y,
	output logic [hcsg_pkg::COORD_BITS-1:0]     to_x,
	output logic [hcsg_pkg::COORD_BITS-1:0]     to_y,
	output logic [7:0]                          red,
	output logic [7:0]                          green,
	output logic [7:0]                          blue,
	output logic                                final_segment
);

	localparam int LB = hcsg_pkg::LVL_BITS;
	localparam int CB = hcsg_pkg::COORD_BITS;
	localparam int HB = hcsg_pkg::HEAD_BITS;
	localparam int PB = hcsg_pkg::PH_BITS;

	// Configuration registers.
	logic [3:0]    depth_q;
	logic [11:0]   step_q;
	logic [11:0]   start_x_q;
	logic [11:0]   start_y_q;

	// Curve state.
	logic [CB-1:0] pen_x_q, pen_y_q;
	logic [HB-1:0] head_q;
	logic [LB-1:0] level_q;
	logic [LB-1:0] run_depth_q;
	logic [LB-1:0] open_q;       // frames on the stack not yet in their exit phase
	logic          done_q;
	logic [PB:0]   stack_q [hcsg_pkg::MAX_DEPTH];

	// Output register.
	logic          out_valid_q;
	logic [CB-1:0] from_x_q, from_y_q, to_x_q, to_y_q;
	hcsg_pkg::rgb_t color_q;
	logic          final_q;

	hcsg_pkg::ctrl_t ctrl;
	hcsg_pkg::stat_t stat;
	logic            busy;

	logic                          in_acc, do_restart;
	logic [hcsg_pkg::IDX_BITS-1:0] top_idx, push_idx;
	logic                          top_kind;
	logic [PB-1:0]                 top_phase;
	logic                          turn_up, push_kind, can_push, do_push, do_close;
	logic [HB-1:0]                 head_inc, head_dec;
	logic [CB-1:0]                 step_c, to_x_c, to_y_c;
	logic [LB-1:0]                 open_next;
	logic [LB-1:0]                 depth_sat;
	logic                          out_free, load_out;

	assign in_ready   = !busy;
	assign in_acc     = in_valid && in_ready;
	assign do_restart = in_acc && restart;

	assign top_idx   = (level_q == '0) ? '0 : hcsg_pkg::IDX_BITS'(level_q - LB'(1));
	assign push_idx  = hcsg_pkg::IDX_BITS'(level_q);
	assign top_kind  = stack_q[top_idx][PB];
	assign top_phase = stack_q[top_idx][PB-1:0];

	assign turn_up   = top_kind ^ ctrl.uw.turn_inv;
	assign push_kind = top_kind ^ ctrl.uw.push_inv;
	assign can_push  = level_q < run_depth_q;
	assign do_push   = ctrl.go && ctrl.uw.push_en && can_push;
	assign do_close  = ctrl.go && ctrl.uw.phase_wr && (ctrl.uw.phase_val == hcsg_pkg::PH_EXIT);

	assign head_inc = (head_q == hcsg_pkg::HEAD_MOD - HB'(1)) ? '0 : head_q + HB'(1);
	assign head_dec = (head_q == '0) ? hcsg_pkg::HEAD_MOD - HB'(1) : head_q - HB'(1);

	// Segment end point; direction is the heading count modulo four.
	assign step_c = CB'(step_q);
	always_comb begin
		to_x_c = pen_x_q;
		to_y_c = pen_y_q;
		case (head_q[1:0])
			2'd0:    to_x_c = pen_x_q + step_c;
			2'd1:    to_y_c = pen_y_q - step_c;
			2'd2:    to_x_c = pen_x_q - step_c;
			default: to_y_c = pen_y_q + step_c;
		endcase
	end

	// The last segment is the one after which every remaining frame is in its exit phase.
	assign open_next = open_q + LB'(do_push) - LB'(do_close);

	assign depth_sat = (5'(depth_q) > 5'(hcsg_pkg::MAX_DEPTH)) ?
		LB'(hcsg_pkg::MAX_DEPTH) : LB'(depth_q);

	assign out_free = !out_valid_q || out_ready;
	assign load_out = ctrl.go && ctrl.uw.draw_en;

	assign stat.start      = in_acc && !restart && !done_q;
	assign stat.level_zero = (level_q == '0);
	assign stat.phase      = top_phase;
	assign stat.out_free   = out_free;

	hcsg_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= 4'd1;
			step_q    <= 12'd1;
			start_x_q <= '0;
			start_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				hcsg_pkg::CFG_DEPTH:   depth_q   <= cfg_data[3:0];
				hcsg_pkg::CFG_STEP:    step_q    <= cfg_data[11:0];
				hcsg_pkg::CFG_START_X: start_x_q <= cfg_data[11:0];
				default:               start_y_q <= cfg_data[11:0];
			endcase
		end
	end

	// Pen, heading and stack control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q     <= '0;
			pen_y_q     <= '0;
			head_q      <= hcsg_pkg::HEAD_START;
			level_q     <= '0;
			run_depth_q <= '0;
			open_q      <= '0;
			done_q      <= 1'b1;
		end else if (do_restart) begin
			pen_x_q     <= CB'(start_x_q);
			pen_y_q     <= CB'(start_y_q);
			head_q      <= hcsg_pkg::HEAD_START;
			run_depth_q <= depth_sat;
			done_q      <= (depth_sat == '0);
			level_q     <= (depth_sat == '0) ? '0 : LB'(1);
			open_q      <= (depth_sat == '0) ? '0 : LB'(1);
		end else begin
			if (ctrl.set_done) done_q <= 1'b1;
			if (ctrl.go && ctrl.uw.turn_en) head_q <= turn_up ? head_inc : head_dec;
			if (load_out) begin
				pen_x_q <= to_x_c;
				pen_y_q <= to_y_c;
			end
			if (do_push) level_q <= level_q + LB'(1);
			else if (ctrl.go && ctrl.uw.pop_en) level_q <= level_q - LB'(1);
			open_q <= open_next;
		end
	end

	// Frame stack: kind in the top bit, phase below. No reset; entries are written
	// before they are read.
	always_ff @(posedge clk) begin
		if (do_restart && depth_sat != '0) begin
			stack_q[0] <= '0;
		end else begin
			if (ctrl.go && ctrl.uw.phase_wr) stack_q[top_idx] <= {top_kind, ctrl.uw.phase_val};
			if (do_push) stack_q[push_idx] <= {push_kind, hcsg_pkg::PH_ENTER};
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			from_x_q <= pen_x_q;
			from_y_q <= pen_y_q;
			to_x_q   <= to_x_c;
			to_y_q   <= to_y_c;
			color_q  <= hcsg_pkg::head_color(head_q);
			final_q  <= (open_next == '0);
		end
	end

	assign out_valid     = out_valid_q;
	assign from_x        = from_x_q;
	assign from_y        = from_y_q;
	assign to_x          = to_x_q;
	assign to_y          = to_y_q;
	assign red           = color_q.r;
	assign green         = color_q.g;
	assign blue          = color_q.b;
	assign final_segment = final_q;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= run_depth_q)
		else $error("frame stack deeper than the latched depth");

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= level_q)
		else $error("open frame count exceeds stack level");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q &&
		$stable({from_x_q, from_y_q, to_x_q, to_y_q, color_q, final_q})))
		else $error("waiting segment changed before it was taken");

endmodule

// File: rtl/core/hcsg_sequencer.sv
// Microcode sequencer of the Hilbert curve segment generator: step counter,
// control store lookup and phase dispatch. Depends on hcsg_pkg.
module hcsg_sequencer (
	input  logic           clk,
	input  logic           arst_n,
	input  hcsg_pkg::stat_t stat,
	output hcsg_pkg::ctrl_t ctrl,
	output logic           busy
);

	logic                          busy_q;
	logic [hcsg_pkg::UPC_BITS-1:0] upc_q;
	hcsg_pkg::uword_t              uw;
	logic                          go;

	assign uw   = hcsg_pkg::ucode(upc_q);
	// A drawing step waits until the output register can take its segment.
	assign go   = busy_q && !(uw.draw_en && !stat.out_free);
	assign busy = busy_q;

	assign ctrl.go       = go;
	assign ctrl.uw       = uw;
	assign ctrl.set_done = go && (uw.jump == hcsg_pkg::J_DISPATCH) && stat.level_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q  <= hcsg_pkg::UA_FETCH;
		end else if (!busy_q) begin
			if (stat.start) begin
				busy_q <= 1'b1;
				upc_q  <= hcsg_pkg::UA_FETCH;
			end
		end else if (go) begin
			unique case (uw.jump)
				hcsg_pkg::J_NEXT: begin
					upc_q <= uw.nxt_addr;
				end
				hcsg_pkg::J_DISPATCH: begin
					if (stat.level_zero) busy_q <= 1'b0;
					else upc_q <= hcsg_pkg::dispatch(stat.phase);
				end
				default: begin
					busy_q <= 1'b0;
				end
			endcase
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !go) |=> (busy_q && $stable(upc_q)))
		else $error("sequencer moved while stalled");

	a_upc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (upc_q <= hcsg_pkg::UA_P4))
		else $error("step counter outside the program");

	a_end_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(go && uw.jump == hcsg_pkg::J_END) |=> !busy_q)
		else $error("sequencer did not return to idle after a drawing step");

endmodule
